### rtl/core/pts_pkg.sv
// package for the priority task scheduler: sizes, codes and command/status structs
package pts_pkg;

  localparam int Tasks = 16;
  localparam int Levels = 32;
  localparam int TaskW = 4;
  localparam int LevelW = 5;
  localparam int PtrW = 5;
  localparam logic [PtrW-1:0] Nil = 5'h10;

  localparam logic [2:0] ModeTick = 3'd0;
  localparam logic [2:0] ModeEnq = 3'd1;
  localparam logic [2:0] ModeSched = 3'd2;
  localparam logic [2:0] ModeSleep = 3'd3;
  localparam logic [2:0] ModeWake = 3'd4;

  localparam logic [1:0] StBlocked = 2'd0;
  localparam logic [1:0] StRunnable = 2'd1;
  localparam logic [1:0] StRunning = 2'd2;
  localparam logic [1:0] StSleeping = 2'd3;

  // operation the controller asks of the datapath
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_TICK_INC = 4'd2,
    OP_TICK_STEP = 4'd3,
    OP_ENQ = 4'd4,
    OP_WAKE = 4'd5,
    OP_SLEEP_UNLINK = 4'd6,
    OP_SLEEP_PUSH = 4'd7,
    OP_SCAN = 4'd8,
    OP_PICK_UNLINK = 4'd9,
    OP_IDLE_FIX = 4'd10,
    OP_COMMIT = 4'd11,
    OP_REQUEUE = 4'd12,
    OP_REJECT = 4'd13
  } pts_op_t;

  typedef struct packed {
    pts_op_t op;
  } pts_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic walk_done;
    logic scan_done;
    logic enq_ok;
    logic wake_ok;
    logic sleep_ok;
    logic requeue;
  } pts_stat_t;

endpackage

### rtl/core/pts_datapath.sv
// scheduler datapath: task tables, list heads, tick counter and result fields
module pts_datapath
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic [3:0] idle_id,
  input  logic [2:0] in_mode,
  input  logic [TaskW-1:0] in_task,
  input  logic [7:0] in_prio,
  input  logic [31:0] in_ticks,
  input  pts_cmd_t cmd,
  output pts_stat_t stat,
  output logic [TaskW-1:0] cur_task,
  output logic current_present,
  output logic switched,
  output logic [TaskW-1:0] previous_task,
  output logic previous_present,
  output logic status
);

  logic [1:0] task_status [Tasks];
  logic [LevelW-1:0] task_priority [Tasks];
  logic [31:0] wake_at [Tasks];
  logic [PtrW-1:0] link_next [Tasks];
  logic [PtrW-1:0] link_prev [Tasks];
  logic [PtrW-1:0] level_head [Levels];
  logic [PtrW-1:0] sleep_head;
  logic [31:0] tick_ctr;
  logic [PtrW-1:0] running_task;

  // latched command and walk state
  logic [2:0] mode;
  logic [TaskW-1:0] tsk;
  logic [7:0] prio;
  logic [31:0] ticks;
  logic [PtrW-1:0] walk;
  logic [LevelW:0] lvl;
  logic [PtrW-1:0] pick;
  logic [PtrW-1:0] prev;

  logic [TaskW-1:0] w;
  logic [TaskW-1:0] pk;
  logic [TaskW-1:0] rt;
  logic [TaskW-1:0] pv;
  logic [LevelW-1:0] lv;
  logic [PtrW-1:0] idle_ptr;

  assign w = walk[TaskW-1:0];
  assign pk = pick[TaskW-1:0];
  assign rt = running_task[TaskW-1:0];
  assign pv = prev[TaskW-1:0];
  assign lv = lvl[LevelW-1:0];
  assign idle_ptr = {1'b0, idle_id};

  // status toward the controller
  always_comb begin
    stat.mode = mode;
    stat.walk_done = (walk == Nil);
    stat.scan_done = lvl[LevelW] || (level_head[lv] != Nil);
    stat.enq_ok = (task_status[tsk] == StBlocked) || (task_status[tsk] == StRunning);
    stat.wake_ok = (task_status[tsk] == StBlocked) || (task_status[tsk] == StSleeping);
    stat.sleep_ok = (running_task != Nil);
    stat.requeue = (prev != Nil) && (pick != prev) && (task_status[pv] == StRunning);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Tasks; i++) begin
        task_status[i] <= StBlocked;
        task_priority[i] <= '0;
        wake_at[i] <= '0;
        link_next[i] <= Nil;
        link_prev[i] <= Nil;
      end
      for (int i = 0; i < Levels; i++) level_head[i] <= Nil;
      sleep_head <= Nil;
      tick_ctr <= '0;
      running_task <= Nil;
      walk <= Nil;
      lvl <= '0;
      pick <= Nil;
      prev <= Nil;
      mode <= '0;
      tsk <= '0;
      prio <= '0;
      ticks <= '0;
      switched <= 1'b0;
      previous_task <= '0;
      previous_present <= 1'b0;
      status <= 1'b0;
    end else begin
      case (cmd.op)
        // capture the beat, clear result flags, start the scan at the top level, note the running task
        OP_LOAD: begin
          mode <= in_mode;
          tsk <= in_task;
          prio <= in_prio;
          ticks <= in_ticks;
          switched <= 1'b0;
          previous_task <= '0;
          previous_present <= 1'b0;
          status <= 1'b0;
          lvl <= (LevelW+1)'(Levels - 1);
          prev <= running_task;
        end
        OP_TICK_INC: begin
          tick_ctr <= tick_ctr + 32'd1;
          walk <= sleep_head;
        end
        // one sleeper per cycle: a due sleeper is unlinked from the sleep list and pushed on its level
        OP_TICK_STEP: begin
          walk <= link_next[w];
          if (tick_ctr >= wake_at[w]) begin
            if (link_prev[w] != Nil) link_next[link_prev[w][TaskW-1:0]] <= link_next[w];
            else sleep_head <= link_next[w];
            if (link_next[w] != Nil) link_prev[link_next[w][TaskW-1:0]] <= link_prev[w];
            link_next[w] <= level_head[task_priority[w]];
            link_prev[w] <= Nil;
            if (level_head[task_priority[w]] != Nil)
              link_prev[level_head[task_priority[w]][TaskW-1:0]] <= walk;
            level_head[task_priority[w]] <= walk;
            task_status[w] <= StRunnable;
          end
        end
        OP_ENQ: begin
          task_priority[tsk] <= (prio > 8'(Levels - 1)) ? LevelW'(Levels - 1)
                                                         : prio[LevelW-1:0];
          link_next[tsk] <= level_head[(prio > 8'(Levels - 1)) ? LevelW'(Levels - 1)
                                                                : prio[LevelW-1:0]];
          link_prev[tsk] <= Nil;
          if (level_head[(prio > 8'(Levels - 1)) ? LevelW'(Levels - 1) : prio[LevelW-1:0]] != Nil)
            link_prev[level_head[(prio > 8'(Levels - 1)) ? LevelW'(Levels - 1)
                                 : prio[LevelW-1:0]][TaskW-1:0]] <= {1'b0, tsk};
          level_head[(prio > 8'(Levels - 1)) ? LevelW'(Levels - 1) : prio[LevelW-1:0]]
            <= {1'b0, tsk};
          task_status[tsk] <= StRunnable;
        end
        // wake of sleeper: unlink from sleep list and push on its level in the same cycle
        // when blocked the task is not unlinked, only pushed
        OP_WAKE: begin
          if (task_status[tsk] == StSleeping) begin
            if (link_prev[tsk] != Nil) link_next[link_prev[tsk][TaskW-1:0]] <= link_next[tsk];
            else sleep_head <= link_next[tsk];
            if (link_next[tsk] != Nil) link_prev[link_next[tsk][TaskW-1:0]] <= link_prev[tsk];
          end
          link_next[tsk] <= level_head[task_priority[tsk]];
          link_prev[tsk] <= Nil;
          if (level_head[task_priority[tsk]] != Nil)
            link_prev[level_head[task_priority[tsk]][TaskW-1:0]] <= {1'b0, tsk};
          level_head[task_priority[tsk]] <= {1'b0, tsk};
          task_status[tsk] <= StRunnable;
        end
        // current task leaves a run list if it was enqueued
        OP_SLEEP_UNLINK: begin
          if (task_status[rt] == StRunnable) begin
            if (link_prev[rt] != Nil) link_next[link_prev[rt][TaskW-1:0]] <= link_next[rt];
            else level_head[task_priority[rt]] <= link_next[rt];
            if (link_next[rt] != Nil) link_prev[link_next[rt][TaskW-1:0]] <= link_prev[rt];
          end
        end
        OP_SLEEP_PUSH: begin
          wake_at[rt] <= tick_ctr + ticks;
          task_status[rt] <= StSleeping;
          link_next[rt] <= sleep_head;
          link_prev[rt] <= Nil;
          if (sleep_head != Nil) link_prev[sleep_head[TaskW-1:0]] <= running_task;
          sleep_head <= running_task;
        end
        // one level per cycle, highest first
        OP_SCAN: begin
          lvl <= lvl - 1'b1;
        end
        OP_PICK_UNLINK: begin
          if (!lvl[LevelW]) begin
            pick <= level_head[lv];
            level_head[lv] <= link_next[level_head[lv][TaskW-1:0]];
            if (link_next[level_head[lv][TaskW-1:0]] != Nil)
              link_prev[link_next[level_head[lv][TaskW-1:0]][TaskW-1:0]] <= Nil;
            link_next[level_head[lv][TaskW-1:0]] <= Nil;
            link_prev[level_head[lv][TaskW-1:0]] <= Nil;
          end else if (idle_ptr < PtrW'(Tasks)) begin
            pick <= idle_ptr;
          end else begin
            pick <= Nil;
          end
        end
        // idle task taken off the sleep list when it sleeps
        OP_IDLE_FIX: begin
          if (lvl[LevelW] && pick != Nil && task_status[pk] == StSleeping) begin
            if (link_prev[pk] != Nil) link_next[link_prev[pk][TaskW-1:0]] <= link_next[pk];
            else sleep_head <= link_next[pk];
            if (link_next[pk] != Nil) link_prev[link_next[pk][TaskW-1:0]] <= link_prev[pk];
            link_next[pk] <= Nil;
            link_prev[pk] <= Nil;
          end
        end
        OP_COMMIT: begin
          if (pick != Nil) task_status[pk] <= StRunning;
          if (pick != prev) begin
            running_task <= pick;
            switched <= 1'b1;
            previous_task <= (prev != Nil) ? pv : '0;
            previous_present <= (prev != Nil);
          end
        end
        OP_REQUEUE: begin
          link_next[pv] <= level_head[task_priority[pv]];
          link_prev[pv] <= Nil;
          if (level_head[task_priority[pv]] != Nil)
            link_prev[level_head[task_priority[pv]][TaskW-1:0]] <= prev;
          level_head[task_priority[pv]] <= prev;
          task_status[pv] <= StRunnable;
        end
        OP_REJECT: begin
          status <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_task = (running_task != Nil) ? rt : '0;
  assign current_present = (running_task != Nil);

endmodule

### rtl/core/pts_ctrl.sv
// scheduler controller: sequences one command through the datapath
module pts_ctrl
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  pts_stat_t stat,
  output pts_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_WALK = 10'b0000000100,
    S_SLPUSH = 10'b0000001000,
    S_SCAN = 10'b0000010000,
    S_PICK = 10'b0000100000,
    S_IDLEFIX = 10'b0001000000,
    S_COMMIT = 10'b0010000000,
    S_REQUEUE = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.op = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_OUT;
        case (stat.mode)
          ModeTick: begin
            cmd.op = OP_TICK_INC;
            state_next = S_WALK;
          end
          ModeEnq: cmd.op = stat.enq_ok ? OP_ENQ : OP_REJECT;
          ModeSched: state_next = S_SCAN;
          ModeSleep: begin
            if (stat.sleep_ok) begin
              cmd.op = OP_SLEEP_UNLINK;
              state_next = S_SLPUSH;
            end else begin
              cmd.op = OP_REJECT;
            end
          end
          ModeWake: cmd.op = stat.wake_ok ? OP_WAKE : OP_REJECT;
          default: cmd.op = OP_REJECT;
        endcase
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_OUT;
        else cmd.op = OP_TICK_STEP;
      end
      S_SLPUSH: begin
        cmd.op = OP_SLEEP_PUSH;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_PICK;
        else cmd.op = OP_SCAN;
      end
      S_PICK: begin
        cmd.op = OP_PICK_UNLINK;
        state_next = S_IDLEFIX;
      end
      S_IDLEFIX: begin
        cmd.op = OP_IDLE_FIX;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.op = OP_COMMIT;
        state_next = stat.requeue ? S_REQUEUE : S_OUT;
      end
      S_REQUEUE: begin
        cmd.op = OP_REQUEUE;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  // no new beat while a result is pending
  a_no_accept_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept during result");
  // an accepted beat leads to decode
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == S_DECODE)) else $error("no decode");
  // state stays one-hot
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
`endif

endmodule

### rtl/core/priority_task_scheduler_top.sv
// Priority task scheduler: one command beat in, one result beat out, one command in
// flight at a time. Each command is loaded, then decoded; enqueue, wake and rejected
// commands act in decode and go to the result. A tick increments the tick counter and
// walks the sleep list one sleeper per cycle. Schedule and sleep scan the priority
// levels one per cycle from the highest, then pick, fix the idle task, commit and
// requeue the previous task when it is still running; sleep first unlinks and pushes
// the current task on the sleep list. The result is held until it is taken.
module priority_task_scheduler_top
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [3:0] cfg_wdata,      // idle task number
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // mode[2:0], task_id[6:3], priority_req[14:7],
                                     // sleep_ticks[46:15], zero pad
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [15:0] m_axis_tdata   // cur_task[3:0], current_present[4], switched[5],
                                     // previous_task[9:6], previous_present[10],
                                     // status[11], zero pad
);

  logic [3:0] idle_id;
  pts_cmd_t cmd;
  pts_stat_t stat;
  logic [TaskW-1:0] cur_task;
  logic current_present;
  logic switched;
  logic [TaskW-1:0] previous_task;
  logic previous_present;
  logic status;

  // idle task register
  always_ff @(posedge clk) begin
    if (rst) idle_id <= '0;
    else if (cfg_we) idle_id <= cfg_wdata;
  end

  pts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  pts_datapath u_dp (
    .clk(clk), .rst(rst), .idle_id(idle_id),
    .in_mode(s_axis_tdata[2:0]), .in_task(s_axis_tdata[6:3]),
    .in_prio(s_axis_tdata[14:7]), .in_ticks(s_axis_tdata[46:15]),
    .cmd(cmd), .stat(stat),
    .cur_task(cur_task), .current_present(current_present),
    .switched(switched), .previous_task(previous_task),
    .previous_present(previous_present), .status(status)
  );

  assign m_axis_tdata = {4'b0, status, previous_present, previous_task,
                         switched, current_present, cur_task};

endmodule

### tb/sv/tb.sv
// testbench for the priority task scheduler: random and directed commands checked by a predictor
`timescale 1ns / 1ps
module tb;
  import pts_pkg::*;

  localparam int NilT = 255;

  typedef struct packed {
    logic [31:0] ticks;
    logic [7:0] prio;
    logic [3:0] task_id;
    logic [2:0] mode;
  } sched_cmd_t;

  typedef struct packed {
    logic status;
    logic prev_present;
    logic [3:0] prev_task;
    logic switched;
    logic cur_present;
    logic [3:0] cur_task;
  } sched_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [3:0] cfg_wdata = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;

  priority_task_scheduler_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // predictor state
  int t_stat[Tasks];
  int t_prio[Tasks];
  logic [31:0] t_wake[Tasks];
  int nxt[Tasks];
  int prv[Tasks];
  int lvl_head[Levels];
  int slp_head;
  logic [31:0] tick_cnt;
  int run_task;
  int idle_sel;

  sched_cmd_t cmd_q[$];
  sched_res_t result_q[$];
  int errors = 0;
  bit stim_done = 0;
  int hold_sends = 0;

  initial forever #10 clk = ~clk;

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int lvl(int t);
    return t_prio[t] < Levels ? t_prio[t] : Levels - 1;
  endfunction

  function automatic void push_ready(int t);
    int h;
    h = lvl_head[lvl(t)];
    nxt[t] = h;
    prv[t] = NilT;
    if (h != NilT) prv[h] = t;
    lvl_head[lvl(t)] = t;
    t_stat[t] = StRunnable;
  endfunction

  function automatic void unlink_ready(int t);
    if (prv[t] != NilT) nxt[prv[t]] = nxt[t]; else lvl_head[lvl(t)] = nxt[t];
    if (nxt[t] != NilT) prv[nxt[t]] = prv[t];
    nxt[t] = NilT;
    prv[t] = NilT;
  endfunction

  function automatic void unlink_sleeper(int t);
    if (prv[t] != NilT) nxt[prv[t]] = nxt[t]; else slp_head = nxt[t];
    if (nxt[t] != NilT) prv[nxt[t]] = prv[t];
    nxt[t] = NilT;
    prv[t] = NilT;
  endfunction

  function automatic void dispatch(ref sched_res_t r);
    int prev, pick;
    prev = run_task;
    pick = NilT;
    for (int p = Levels - 1; p >= 0; p--)
      if (pick == NilT && lvl_head[p] != NilT) begin
        pick = lvl_head[p];
        unlink_ready(pick);
      end
    if (pick == NilT && idle_sel < Tasks) begin
      pick = idle_sel;
      if (t_stat[pick] == StSleeping) unlink_sleeper(pick);
    end
    if (pick == prev) begin
      if (pick != NilT) t_stat[pick] = StRunning;
      return;
    end
    run_task = pick;
    if (pick != NilT) t_stat[pick] = StRunning;
    if (prev != NilT && t_stat[prev] == StRunning) push_ready(prev);
    r.switched = 1;
    r.prev_task = prev != NilT ? 4'(prev) : 4'd0;
    r.prev_present = prev != NilT;
  endfunction

  function automatic sched_res_t predict_schedule(sched_cmd_t c);
    sched_res_t r;
    int t, nx, cur;
    r = '0;
    t = c.task_id;
    case (c.mode)
      ModeTick: begin
        tick_cnt++;
        cur = slp_head;
        for (int g = 0; g < Tasks && cur != NilT; g++) begin
          nx = nxt[cur];
          if (tick_cnt >= t_wake[cur]) begin
            unlink_sleeper(cur);
            push_ready(cur);
          end
          cur = nx;
        end
      end
      ModeEnq: begin
        if (t_stat[t] == StRunnable || t_stat[t] == StSleeping) r.status = 1;
        else begin
          t_prio[t] = c.prio > Levels - 1 ? Levels - 1 : c.prio;
          push_ready(t);
        end
      end
      ModeSched: dispatch(r);
      ModeSleep: begin
        cur = run_task;
        if (cur == NilT) r.status = 1;
        else begin
          if (t_stat[cur] == StRunnable) unlink_ready(cur);
          t_wake[cur] = tick_cnt + c.ticks;
          t_stat[cur] = StSleeping;
          nxt[cur] = slp_head;
          prv[cur] = NilT;
          if (slp_head != NilT) prv[slp_head] = cur;
          slp_head = cur;
          dispatch(r);
        end
      end
      ModeWake: begin
        if (t_stat[t] == StSleeping) begin
          unlink_sleeper(t);
          push_ready(t);
        end else if (t_stat[t] == StBlocked) push_ready(t);
        else r.status = 1;
      end
      default: r.status = 1;
    endcase
    r.cur_task = run_task != NilT ? 4'(run_task) : 4'd0;
    r.cur_present = run_task != NilT;
    return r;
  endfunction

  // input beats taken at the rising edge feed the predictor
  bit in_taken = 0;
  always @(posedge clk) begin
    in_taken = 0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      result_q.push_back(predict_schedule(sched_cmd_t'(s_axis_tdata[46:0])));
      in_taken = 1;
    end
  end

  // driver: one command beat per item after a random gap
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        send_gap = $urandom_range(0, 12);
        if (($urandom_range(0, 3) == 0)) send_gap = 0;
      end
      if (!s_axis_tvalid || in_taken) begin
        if (send_gap > 0 || hold_sends > 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 0;
        end else if (cmd_q.size() > 0) begin
          s_axis_tdata <= {1'b0, cmd_q.pop_front()};
          s_axis_tvalid <= 1;
        end else s_axis_tvalid <= 0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  int stall = 0;
  bit out_taken = 0;
  always @(posedge clk) begin
    sched_res_t got, want;
    out_taken = 0;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      out_taken = 1;
      got = sched_res_t'(m_axis_tdata[11:0]);
      if (result_q.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.cur_task !== want.cur_task) begin
          $error("cur_task exp %0d got %0d", want.cur_task, got.cur_task); errors++;
        end
        if (got.cur_present !== want.cur_present) begin
          $error("current_present exp %0d got %0d", want.cur_present, got.cur_present); errors++;
        end
        if (got.switched !== want.switched) begin
          $error("switched exp %0d got %0d", want.switched, got.switched); errors++;
        end
        if (got.prev_task !== want.prev_task) begin
          $error("previous_task exp %0d got %0d", want.prev_task, got.prev_task); errors++;
        end
        if (got.prev_present !== want.prev_present) begin
          $error("previous_present exp %0d got %0d", want.prev_present, got.prev_present);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
      end
    end
  end

  // receiver stalls drawn per result beat
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) stall = $urandom_range(0, 12);
      if (stall > 0 && $urandom_range(0, 4) != 0) begin
        stall--;
        m_axis_tready <= 0;
      end else begin
        stall = 0;
        m_axis_tready <= 1;
      end
    end
  end

  function automatic sched_cmd_t mk(int m, int t, int p, logic [31:0] k);
    sched_cmd_t c;
    c.mode = 3'(m);
    c.task_id = 4'(t);
    c.prio = 8'(p);
    c.ticks = k;
    return c;
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_idle(int v);
    @(negedge clk);
    cfg_wdata <= 4'(v);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    idle_sel = v;
  endtask

  function automatic void random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) cmd_q.push_back(mk(ModeTick, 0, 0, 0));
      else if (r < 45) cmd_q.push_back(mk(ModeEnq, $urandom_range(0, 15),
                                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                          : $urandom_range(0, 40), $urandom()));
      else if (r < 65) cmd_q.push_back(mk(ModeSched, $urandom(), $urandom(), $urandom()));
      else if (r < 80) cmd_q.push_back(mk(ModeSleep, $urandom(), $urandom(),
                                          $urandom_range(0, 7) == 0 ? $urandom()
                                          : $urandom_range(0, 6)));
      else if (r < 96) cmd_q.push_back(mk(ModeWake, $urandom_range(0, 15), $urandom(),
                                          $urandom()));
      else cmd_q.push_back(mk($urandom_range(5, 7), $urandom(), $urandom(), $urandom()));
    end
  endfunction

  initial begin
    for (int i = 0; i < Tasks; i++) begin
      t_stat[i] = StBlocked; t_prio[i] = 0; t_wake[i] = 0; nxt[i] = NilT; prv[i] = NilT;
    end
    for (int i = 0; i < Levels; i++) lvl_head[i] = NilT;
    slp_head = NilT;
    tick_cnt = 0;
    run_task = NilT;
    idle_sel = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    set_idle(15);
    // directed: every mode, field extremes, corner cases
    cmd_q.push_back(mk(ModeSched, 0, 0, 0));
    cmd_q.push_back(mk(ModeSleep, 0, 0, 0));
    cmd_q.push_back(mk(ModeEnq, 3, 255, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(ModeEnq, 3, 7, 0));
    cmd_q.push_back(mk(ModeEnq, 5, 31, 0));
    cmd_q.push_back(mk(ModeEnq, 0, 0, 0));
    cmd_q.push_back(mk(ModeSched, 15, 255, 0));
    cmd_q.push_back(mk(ModeEnq, 15, 31, 0));
    cmd_q.push_back(mk(ModeSched, 0, 0, 0));
    cmd_q.push_back(mk(ModeSched, 0, 0, 0));
    cmd_q.push_back(mk(ModeSleep, 0, 0, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(ModeSleep, 0, 0, 2));
    cmd_q.push_back(mk(ModeWake, 3, 0, 0));
    cmd_q.push_back(mk(ModeWake, 15, 0, 0));
    cmd_q.push_back(mk(ModeWake, 9, 0, 0));
    cmd_q.push_back(mk(ModeTick, 0, 0, 0));
    cmd_q.push_back(mk(ModeTick, 0, 0, 0));
    cmd_q.push_back(mk(ModeTick, 0, 0, 0));
    cmd_q.push_back(mk(5, 15, 255, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(7, 0, 0, 0));
    cmd_q.push_back(mk(6, 0, 0, 0));
    drain();
    // sleeping idle task picked as idle
    set_idle(0);
    cmd_q.push_back(mk(ModeEnq, 0, 1, 0));
    cmd_q.push_back(mk(ModeSched, 0, 0, 0));
    cmd_q.push_back(mk(ModeSleep, 0, 0, 100));
    cmd_q.push_back(mk(ModeSleep, 0, 0, 100));
    drain();
    random_burst(600);
    // sender pauses mid-burst until every result is back
    wait (cmd_q.size() < 300);
    hold_sends = 1;
    wait (result_q.size() == 0 && !s_axis_tvalid);
    hold_sends = 0;
    drain();
    set_idle($urandom_range(1, 14));
    random_burst(550);
    drain();
    set_idle(15);
    random_burst(550);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
